// ===== rtl/hcpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpd_pkg
// Shared types, codes and helpers for the hex checksum packet deframer.
// ----------------------------------------------------------------------------
package hcpd_pkg;

    localparam int unsigned DEF_BUF_BYTES = 16384;

    localparam int unsigned LEN_W = 14;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
    localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_HI   = 2'd2,
        PH_LO   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       byte_value;
        logic [LEN_W-1:0] packet_length;
        logic [7:0]       computed_sum;
    } result_t;

    // Lenient hex digit: 0-9, A-Z and a-z give 0..35, anything else 0.
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c inside {[8'h30:8'h39]})
            begin
                v = c - 8'h30;
            end
            else if (c inside {[8'h41:8'h5A]})
            begin
                v = c - 8'h41 + 8'd10;
            end
            else if (c inside {[8'h61:8'h7A]})
            begin
                v = c - 8'h61 + 8'd10;
            end
            digit_value = v[5:0];
        end
    endfunction

endpackage

// ===== rtl/hex_checksum_packet_deframer.sv =====
`timescale 1ns / 1ps
// A result beat enters the output buffer when its input beat is accepted.
// Throughput: one input beat per cycle while the skid slot is free
// (in_ready); the per-byte update is a single registered pass over the
// deframer state. A two-slot output buffer keeps input flowing across one
// stalled result. Reset (rst_n, async, active low) puts the deframer in
// hunt, clears sum, length and high digit, and empties the output buffer.
// ----------------------------------------------------------------------------
// hex_checksum_packet_deframer
// '$'-framed, '#'-terminated packet deframer with a two-digit lenient hex
// checksum. Forwards payload bytes with running length and sum, then an
// ack ('+') or nack ('-') beat at packet end.
// ----------------------------------------------------------------------------
module hex_checksum_packet_deframer
    import hcpd_pkg::*;
#(
    parameter int unsigned BUF_BYTES = DEF_BUF_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       byte_value,
    output logic [LEN_W-1:0] packet_length,
    output logic [7:0]       computed_sum
);

    // Count holds up to BUF_BYTES-1.
    localparam int unsigned CNT_W = (BUF_BYTES > 2) ? $clog2(BUF_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUF_BYTES - 1);

    phase_t           phase_reg,  phase_next;
    logic [7:0]       sum_reg,    sum_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [5:0]       high_reg,   high_next;

    logic             accept;
    logic             res_valid;
    result_t          res;
    result_t          out_data;
    logic             can_push;

    logic [31:0]      count_wide;
    logic [9:0]       recv_sum;
    logic             sum_match;

    assign in_ready = can_push;
    assign accept   = in_valid && in_ready;

    // Received checksum keeps the full decoded high digit, so a high digit
    // of 16 or more can never match.
    assign recv_sum  = {high_reg, 4'b0000} | {4'b0000, digit_value(rx_byte)};
    assign sum_match = (recv_sum == {2'b00, sum_reg});

    assign count_wide = 32'(count_next);

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        high_next  = high_reg;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == CH_START)
                begin
                    sum_next   = 8'd0;
                    count_next = '0;
                    high_next  = 6'd0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (rx_byte == CH_END)
                begin
                    phase_next = PH_HI;
                end
                else
                begin
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_reg + 1'b1;
                    // Buffer full: next byte is read as the first digit.
                    if (count_next == CNT_LIMIT)
                    begin
                        phase_next = PH_HI;
                    end
                    res_valid         = 1'b1;
                    res.kind          = KIND_DATA;
                    res.byte_value    = rx_byte;
                    res.packet_length = count_wide[LEN_W-1:0];
                    res.computed_sum  = sum_next;
                end
            end
            PH_HI:
            begin
                high_next  = digit_value(rx_byte);
                phase_next = PH_LO;
            end
            PH_LO:
            begin
                phase_next        = PH_HUNT;
                res_valid         = 1'b1;
                res.kind          = sum_match ? KIND_GOOD : KIND_BAD;
                res.byte_value    = sum_match ? CH_ACK : CH_NACK;
                res.packet_length = count_wide[LEN_W-1:0];
                res.computed_sum  = sum_reg;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            count_reg <= '0;
            high_reg  <= 6'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            high_reg  <= high_next;
        end
    end

    // Result beats go through the output register / skid pair.
    hcpd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind          = out_data.kind;
    assign byte_value    = out_data.byte_value;
    assign packet_length = out_data.packet_length;
    assign computed_sum  = out_data.computed_sum;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LIMIT)
        else $error("payload count beyond buffer limit");

    a_start_enters_data: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_HUNT && rx_byte == CH_START
        |=> phase_reg == PH_DATA && count_reg == '0 && sum_reg == 8'd0)
        else $error("start mark did not open a packet");

    a_end_beat_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_LO |=> phase_reg == PH_HUNT)
        else $error("packet end did not return to hunt");

    a_ack_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_GOOD |-> byte_value == CH_ACK)
        else $error("good end beat without ack character");
`endif

endmodule

// ===== rtl/hcpd_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpd_skid
// Two-slot result buffer: output register plus one skid slot, so a new
// beat can be pushed while the output beat is stalled.
// ----------------------------------------------------------------------------
module hcpd_skid
    import hcpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    logic    out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output slot empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled output beat changed");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push into full buffer");
`endif

endmodule

// ===== bench/hex_checksum_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_checksum_packet_deframer_tb
// Self-checking bench for the '$'/'#' packet deframer. A byte queue feeds a
// valid/ready driver; each accepted byte runs through a local deframer model
// that queues the expected result beats, and a monitor pops and compares
// them field by field as the block hands them out. Covers hunt noise, empty
// packets, lenient checksum digits, broken frames and back-pressure.
// ----------------------------------------------------------------------------
module hex_checksum_packet_deframer_tb;
    import hcpd_pkg::*;

    localparam int unsigned BUF_BYTES    = DEF_BUF_BYTES;
    localparam int unsigned RANDOM_BYTES = 1800;   // packet bytes in the random part
    localparam int unsigned PRESSURE_PKT = 60;     // random packet that freezes the sink
    localparam int unsigned RX_HOLD      = 60;     // sink hold-off, in cycles
    localparam int unsigned TAIL_CYCLES  = 10;     // extra settling cycles after the last result
    localparam int unsigned MAX_PRINTED  = 100;
    localparam int unsigned TIMEOUT_NS   = 40_000_000;

    // One byte waiting to go out on the link, plus bench-side controls.
    typedef struct {
        logic [7:0] value;
        bit         drain_first;   // hold this byte until every result is back
        bit         hold_rx;       // freeze the sink once this byte is taken
    } link_byte_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [7:0]       rx_byte   = 8'h00;
    logic             hold_flag = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] packet_length;
    logic [7:0]       computed_sum;

    link_byte_t  link_bytes[$];        // bytes not yet offered to the block
    link_byte_t  offered;
    result_t     expected_beats[$];    // predicted result beats, oldest first

    int unsigned bytes_queued   = 0;
    int unsigned bytes_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;
    bit          send_calm      = 1'b0;
    bit          recv_calm      = 1'b0;

    // Deframer model state (reset values match the block's reset).
    phase_t      dfr_phase = PH_HUNT;
    logic [7:0]  dfr_sum   = 8'h00;
    int unsigned dfr_count = 0;
    logic [5:0]  dfr_high  = 6'd0;

    hex_checksum_packet_deframer #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .byte_value    (byte_value),
        .packet_length (packet_length),
        .computed_sum  (computed_sum)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Lenient checksum digit: 0-9 -> 0..9, letters of either case -> 10..35,
    // every other byte -> 0.
    function automatic logic [5:0] checksum_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 6'(c - "0");
        if (c >= "A" && c <= "Z")
            return 6'(c - "A" + 8'd10);
        if (c >= "a" && c <= "z")
            return 6'(c - "a" + 8'd10);
        return 6'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10)
            return "0" + 8'(nib);
        return (lower ? "a" : "A") + 8'(nib) - 8'd10;
    endfunction

    // Idle length: mostly none or short, now and then long. Calm stretches
    // run with no idling at all.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_byte(input logic [7:0] value, input bit drain = 1'b0,
                              input bit hold = 1'b0);
        link_byte_t item;
        item.value       = value;
        item.drain_first = drain;
        item.hold_rx     = hold;
        link_bytes.push_back(item);
        bytes_queued++;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] ERROR result beat %0d: %s", $time, results_seen, what);
        mismatch_count++;
    endtask

    // Advance the deframer model by one accepted byte; queue the result
    // beat it causes, if any.
    task automatic deframe_byte(input logic [7:0] c);
        logic [9:0] received;
        result_t    beat;
        beat = '0;
        case (dfr_phase)
            PH_HUNT:
            begin
                // Everything but a start mark is dropped while hunting.
                if (c == CH_START)
                begin
                    dfr_sum   = 8'h00;
                    dfr_count = 0;
                    dfr_high  = 6'd0;
                    dfr_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (c == CH_END)
                begin
                    dfr_phase = PH_HI;
                end
                else
                begin
                    // A '$' here is plain payload.
                    dfr_sum   = dfr_sum + c;
                    dfr_count = dfr_count + 1;
                    // Length limit: the next byte is the first digit, even '#'.
                    if (dfr_count + 1 >= BUF_BYTES)
                        dfr_phase = PH_HI;
                    beat.kind          = KIND_DATA;
                    beat.byte_value    = c;
                    beat.packet_length = dfr_count[LEN_W-1:0];
                    beat.computed_sum  = dfr_sum;
                    expected_beats.push_back(beat);
                end
            end
            PH_HI:
            begin
                dfr_high  = checksum_digit(c);
                dfr_phase = PH_LO;
            end
            PH_LO:
            begin
                // High digit kept at full width: 16 or more can never match.
                received = {dfr_high, 4'h0} | {4'h0, checksum_digit(c)};
                if (received == {2'b00, dfr_sum})
                begin
                    beat.kind       = KIND_GOOD;
                    beat.byte_value = CH_ACK;
                end
                else
                begin
                    beat.kind       = KIND_BAD;
                    beat.byte_value = CH_NACK;
                end
                beat.packet_length = dfr_count[LEN_W-1:0];
                beat.computed_sum  = dfr_sum;
                expected_beats.push_back(beat);
                dfr_phase = PH_HUNT;
            end
            default:
            begin
                dfr_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic check_result_beat();
        result_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h len=%0d sum=%02h",
                                      kind, byte_value, packet_length, computed_sum));
            return;
        end
        want = expected_beats.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (byte_value !== want.byte_value)
            report_mismatch($sformatf("byte_value %02h, expected %02h",
                                      byte_value, want.byte_value));
        if (packet_length !== want.packet_length)
            report_mismatch($sformatf("packet_length %0d, expected %0d",
                                      packet_length, want.packet_length));
        if (computed_sum !== want.computed_sum)
            report_mismatch($sformatf("computed_sum %02h, expected %02h",
                                      computed_sum, want.computed_sum));
    endtask

    // ------------------------------------------------------------------------
    // Link driver: offers queued bytes with random gaps. An offered beat
    // stays up, unchanged, until the block takes it. A byte marked
    // drain_first is held back until every expected result has come out.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            rx_byte   <= 8'h00;
            hold_flag <= 1'b0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte);
                bytes_taken++;
                send_gap = pick_gap(send_calm);
                if ($urandom_range(0, 63) == 0)
                    send_calm = !send_calm;
            end
            // Only pick a new beat when nothing is left hanging.
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() != 0 &&
                         !(link_bytes[0].drain_first && expected_beats.size() != 0))
                begin
                    offered = link_bytes.pop_front();
                    in_valid  <= 1'b1;
                    rx_byte   <= offered.value;
                    hold_flag <= offered.hold_rx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and sink: checks every accepted result beat, stalls at
    // random after results, and freezes when a marked byte goes in so the
    // output buffer fills and in_ready drops.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result_beat();
                results_seen++;
                stall_left = pick_gap(recv_calm);
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
            end
            if (in_valid && in_ready && hold_flag)
                hold_left = RX_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned random_bytes;
        int unsigned packets;
        int unsigned len;
        logic [7:0]  b;
        logic [7:0]  sum;
        bit          lower;
        bit          drain;
        bit          hold;

        // Directed: noise while hunting, then the empty packet.
        queue_byte(8'h00); queue_byte(8'hFF); queue_byte(CH_END);
        queue_byte(CH_START); queue_byte(CH_END); queue_byte("0"); queue_byte("0");
        // Extreme bytes and a '$' inside the payload; sum A3, lowercase digits.
        queue_byte(CH_START); queue_byte(8'hFF); queue_byte(8'h00); queue_byte(CH_START);
        queue_byte(8'h80); queue_byte(CH_END); queue_byte("a"); queue_byte("3");
        // First digit 'Z' decodes to 35, out of range for any sum: nack.
        queue_byte(CH_START); queue_byte(8'h01); queue_byte(CH_END);
        queue_byte("Z"); queue_byte("1");
        // High bytes as checksum digits decode to zero: nack against 7F.
        queue_byte(CH_START); queue_byte(8'h7F); queue_byte(CH_END);
        queue_byte(8'hC5); queue_byte(8'hF5);

        // Random packets: mostly well formed, some broken, with hunt noise.
        random_bytes = 0;
        packets      = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    b = 8'($urandom_range(0, 255));
                    queue_byte((b == CH_START) ? CH_END : b);
                end
            end
            drain = (packets % 40 == 0) || (packets == PRESSURE_PKT);
            if ($urandom_range(0, 4) != 0 || packets == PRESSURE_PKT)
            begin
                if (packets == PRESSURE_PKT)
                    len = 40;
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(11, 60);
                else
                    len = $urandom_range(0, 10);
                queue_byte(CH_START, drain);
                sum = 8'h00;
                for (int i = 0; i < len; i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_END)
                        b = CH_START;
                    sum += b;
                    hold = (packets == PRESSURE_PKT) && (i == 2);
                    queue_byte(b, 1'b0, hold);
                end
                queue_byte(CH_END);
                if ($urandom_range(0, 3) != 0)
                begin
                    lower = $urandom_range(0, 1);
                    queue_byte(hex_char(sum[7:4], lower));
                    queue_byte(hex_char(sum[3:0], lower));
                end
                else
                begin
                    repeat (2)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            queue_byte(hex_char(4'($urandom_range(0, 15)),
                                                $urandom_range(0, 1)));
                        else
                            queue_byte(8'($urandom_range(0, 255)));
                    end
                end
                random_bytes += len + 4;
            end
            else
            begin
                // Broken frame: start mark then raw bytes, '#' allowed.
                queue_byte(CH_START, drain);
                len = $urandom_range(1, 8);
                repeat (len)
                    queue_byte(8'($urandom_range(0, 255)));
                random_bytes += len + 1;
            end
            packets++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be taken and every result to come out.
        while (bytes_taken != bytes_queued)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #TIMEOUT_NS;
        $display("[%0t] ERROR timeout: %0d of %0d bytes taken, %0d results pending",
                 $time, bytes_taken, bytes_queued, expected_beats.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== hex_checksum_packet_deframer.f =====
rtl/hcpd_pkg.sv
rtl/hcpd_skid.sv
rtl/hex_checksum_packet_deframer.sv
bench/hex_checksum_packet_deframer_tb.sv
